[rtl/vt100esc_pkg.sv]
// Shared types, constants and helper functions of the terminal escape parser.
`timescale 1ns / 1ps
`default_nettype none

package vt100esc_pkg;

    localparam int ROWS  = 25;
    localparam int COLS  = 80;
    localparam int TOTAL = ROWS * COLS;

    localparam int CELL_W = 11;
    localparam int ROW_W  = 5;
    localparam int COL_W  = 7;
    localparam int ARG_W  = 14;
    localparam int ACC_W  = ARG_W + 4;
    localparam int MUL_W  = 21;
    localparam int CMD_W  = 3;
    localparam int ATTR_W = 16;
    localparam int BYTE_W = 8;

    localparam int ARG_MAX       = 9999;
    localparam int LAST_ROW_BASE = (ROWS - 1) * COLS;

    // Row of a cell is (cell * DIV_MUL) >> DIV_SHIFT, exact for every cell below TOTAL.
    localparam int DIV_MUL   = 1639;
    localparam int DIV_SHIFT = 17;
    localparam int DIV_W     = ROW_W + DIV_SHIFT;

    localparam int OUT_FIELDS_W = CMD_W + 3 * CELL_W + 2 * ROW_W + 2 * ATTR_W;
    localparam int OUT_TDATA_W  = ((OUT_FIELDS_W + 7) / 8) * 8;
    localparam int OUT_PAD_W    = OUT_TDATA_W - OUT_FIELDS_W;

    localparam logic [CMD_W-1:0] CMD_NONE        = 3'd0;
    localparam logic [CMD_W-1:0] CMD_CURSOR      = 3'd1;
    localparam logic [CMD_W-1:0] CMD_FILL        = 3'd2;
    localparam logic [CMD_W-1:0] CMD_SCROLL_UP   = 3'd3;
    localparam logic [CMD_W-1:0] CMD_SCROLL_DOWN = 3'd4;

    localparam logic [BYTE_W-1:0] CH_ESC      = 8'h1B;
    localparam logic [BYTE_W-1:0] CH_SPACE    = 8'h20;
    localparam logic [BYTE_W-1:0] CH_ZERO     = 8'h30;
    localparam logic [BYTE_W-1:0] CH_SEVEN    = 8'h37;
    localparam logic [BYTE_W-1:0] CH_EIGHT    = 8'h38;
    localparam logic [BYTE_W-1:0] CH_NINE     = 8'h39;
    localparam logic [BYTE_W-1:0] CH_SEMI     = 8'h3B;
    localparam logic [BYTE_W-1:0] CH_QUEST    = 8'h3F;
    localparam logic [BYTE_W-1:0] CH_UP_A     = 8'h41;
    localparam logic [BYTE_W-1:0] CH_UP_B     = 8'h42;
    localparam logic [BYTE_W-1:0] CH_UP_C     = 8'h43;
    localparam logic [BYTE_W-1:0] CH_UP_D     = 8'h44;
    localparam logic [BYTE_W-1:0] CH_UP_H     = 8'h48;
    localparam logic [BYTE_W-1:0] CH_UP_J     = 8'h4A;
    localparam logic [BYTE_W-1:0] CH_UP_K     = 8'h4B;
    localparam logic [BYTE_W-1:0] CH_UP_M     = 8'h4D;
    localparam logic [BYTE_W-1:0] CH_LBRACKET = 8'h5B;
    localparam logic [BYTE_W-1:0] CH_LOW_M    = 8'h6D;
    localparam logic [BYTE_W-1:0] CH_LOW_R    = 8'h72;

    localparam logic [ARG_W-1:0] ERASE_TO_END   = 14'd0;
    localparam logic [ARG_W-1:0] ERASE_TO_START = 14'd1;
    localparam logic [ARG_W-1:0] ERASE_ALL      = 14'd2;

    localparam logic [ARG_W-1:0] SGR_RESET      = 14'd0;
    localparam logic [ARG_W-1:0] SGR_BOLD       = 14'd1;
    localparam logic [ARG_W-1:0] SGR_DIM        = 14'd2;
    localparam logic [ARG_W-1:0] SGR_BLINK      = 14'd5;
    localparam logic [ARG_W-1:0] SGR_REVERSE    = 14'd7;
    localparam logic [ARG_W-1:0] SGR_FG_FIRST   = 14'd30;
    localparam logic [ARG_W-1:0] SGR_FG_LAST    = 14'd37;
    localparam logic [ARG_W-1:0] SGR_FG_DEFAULT = 14'd39;
    localparam logic [ARG_W-1:0] SGR_BG_FIRST   = 14'd40;
    localparam logic [ARG_W-1:0] SGR_BG_LAST    = 14'd47;
    localparam logic [ARG_W-1:0] SGR_BG_DEFAULT = 14'd49;

    localparam logic [ATTR_W-1:0] ATTR_DEFAULT = 16'h0700;
    localparam logic [ATTR_W-1:0] ATTR_BOLD    = 16'h0800;
    localparam logic [ATTR_W-1:0] ATTR_BLINK   = 16'h8000;

    typedef enum logic [2:0] {
        ST_NORMAL = 3'd0,
        ST_ESC    = 3'd1,
        ST_CSI    = 3'd2,
        ST_CSI2   = 3'd3,
        ST_QUEST  = 3'd4
    } parse_state_t;

    typedef struct packed {
        logic [ATTR_W-1:0] char_attr;
        logic [ATTR_W-1:0] fill_word;
        logic [ROW_W-1:0]  region_bottom;
        logic [ROW_W-1:0]  region_top;
        logic [CELL_W-1:0] fill_count;
        logic [CELL_W-1:0] fill_start;
        logic [CELL_W-1:0] cursor_pos;
        logic [CMD_W-1:0]  command;
    } result_t;

    function automatic logic [ARG_W-1:0] add_digit(input logic [ARG_W-1:0] a,
                                                   input logic [3:0] d);
        logic [ACC_W-1:0] v;
        v = ACC_W'(a) * ACC_W'(10) + ACC_W'(d);
        return (v > ACC_W'(ARG_MAX)) ? ARG_W'(ARG_MAX) : v[ARG_W-1:0];
    endfunction

    // One-based argument to a zero-based index, held below the limit.
    function automatic logic [ARG_W-1:0] clamp_index(input logic [ARG_W-1:0] arg,
                                                     input logic [ARG_W-1:0] limit);
        logic [ARG_W-1:0] v;
        v = (arg == '0) ? '0 : arg - ARG_W'(1);
        return (v >= limit) ? limit - ARG_W'(1) : v;
    endfunction

endpackage

`default_nettype wire

[rtl/vt100esc_core.sv]
// Parser state, cursor and attribute registers with the per-byte decode logic.
`timescale 1ns / 1ps
`default_nettype none

module vt100esc_core (
    input  wire logic                                 aclk,
    input  wire logic                                 aresetn,
    input  wire logic                                 step_valid,
    input  wire logic [vt100esc_pkg::BYTE_W-1:0]      rx_byte,
    input  wire logic [vt100esc_pkg::ATTR_W-1:0]      normal_attr,
    output vt100esc_pkg::result_t                     result
);

    vt100esc_pkg::parse_state_t parse_state_reg, parse_state_next;

    logic [vt100esc_pkg::ARG_W-1:0]  first_arg_reg, first_arg_next;
    logic [vt100esc_pkg::ARG_W-1:0]  second_arg_reg, second_arg_next;
    logic [vt100esc_pkg::CELL_W-1:0] cursor_reg, cursor_next;
    logic [vt100esc_pkg::CELL_W-1:0] saved_reg, saved_next;
    logic [vt100esc_pkg::ROW_W-1:0]  scroll_top_reg, scroll_top_next;
    logic [vt100esc_pkg::ROW_W-1:0]  scroll_bottom_reg, scroll_bottom_next;
    logic [vt100esc_pkg::ATTR_W-1:0] attr_reg, attr_next;
    logic [vt100esc_pkg::ROW_W-1:0]  row_reg, row_next;

    logic [vt100esc_pkg::DIV_W-1:0]  row_prod;
    logic [vt100esc_pkg::CELL_W-1:0] col_full;
    logic [vt100esc_pkg::COL_W-1:0]  cur_col;
    logic                            is_digit;
    logic [vt100esc_pkg::ARG_W-1:0]  count_arg;
    logic [vt100esc_pkg::MUL_W-1:0]  count_cols;
    logic [vt100esc_pkg::MUL_W-1:0]  pos_wide;
    logic [vt100esc_pkg::MUL_W-1:0]  down_sum;
    logic [vt100esc_pkg::MUL_W-1:0]  right_sum;
    logic [vt100esc_pkg::ARG_W-1:0]  fg_code;
    logic [vt100esc_pkg::ARG_W-1:0]  bg_code;
    logic [vt100esc_pkg::ROW_W-1:0]  arg_row;
    logic [vt100esc_pkg::ROW_W-1:0]  arg_row2;
    logic [vt100esc_pkg::COL_W-1:0]  arg_col;
    logic [7:0]                      rev_hb;
    logic [vt100esc_pkg::CMD_W-1:0]  cmd;
    logic [vt100esc_pkg::CELL_W-1:0] fill_start;
    logic [vt100esc_pkg::CELL_W-1:0] fill_count;

    // The row of the cursor is registered from the cursor register and follows it in the
    // next cycle. It is only read for a CSI final byte, which always follows at least two
    // bytes that leave the cursor alone, so the registered row is current by then.
    assign row_prod = vt100esc_pkg::DIV_W'(cursor_reg)
                    * vt100esc_pkg::DIV_W'(vt100esc_pkg::DIV_MUL);
    assign row_next = row_prod[vt100esc_pkg::DIV_W-1:vt100esc_pkg::DIV_SHIFT];
    assign col_full = cursor_reg - vt100esc_pkg::CELL_W'(row_reg)
                    * vt100esc_pkg::CELL_W'(vt100esc_pkg::COLS);
    assign cur_col  = col_full[vt100esc_pkg::COL_W-1:0];

    assign is_digit   = (rx_byte >= vt100esc_pkg::CH_ZERO) && (rx_byte <= vt100esc_pkg::CH_NINE);
    assign count_arg  = (first_arg_reg == '0) ? vt100esc_pkg::ARG_W'(1) : first_arg_reg;
    assign count_cols = vt100esc_pkg::MUL_W'(count_arg)
                      * vt100esc_pkg::MUL_W'(vt100esc_pkg::COLS);
    assign pos_wide   = vt100esc_pkg::MUL_W'(cursor_reg);
    assign down_sum   = pos_wide + count_cols;
    assign right_sum  = pos_wide + vt100esc_pkg::MUL_W'(count_arg);
    assign fg_code    = first_arg_reg - vt100esc_pkg::SGR_FG_FIRST;
    assign bg_code    = first_arg_reg - vt100esc_pkg::SGR_BG_FIRST;
    assign arg_row    = vt100esc_pkg::ROW_W'(vt100esc_pkg::clamp_index(first_arg_reg,
                            vt100esc_pkg::ARG_W'(vt100esc_pkg::ROWS)));
    assign arg_row2   = vt100esc_pkg::ROW_W'(vt100esc_pkg::clamp_index(second_arg_reg,
                            vt100esc_pkg::ARG_W'(vt100esc_pkg::ROWS)));
    assign arg_col    = vt100esc_pkg::COL_W'(vt100esc_pkg::clamp_index(second_arg_reg,
                            vt100esc_pkg::ARG_W'(vt100esc_pkg::COLS)));
    assign rev_hb     = {attr_reg[15], attr_reg[10:8], attr_reg[11], attr_reg[14:12]};

    always_comb begin
        parse_state_next = parse_state_reg;
        if (step_valid) begin
            parse_state_next = vt100esc_pkg::ST_NORMAL;
            unique case (parse_state_reg)
                vt100esc_pkg::ST_ESC: begin
                    if (rx_byte == vt100esc_pkg::CH_LBRACKET) begin
                        parse_state_next = vt100esc_pkg::ST_CSI;
                    end
                end
                vt100esc_pkg::ST_CSI: begin
                    if (is_digit) begin
                        parse_state_next = vt100esc_pkg::ST_CSI;
                    end else if (rx_byte == vt100esc_pkg::CH_SEMI) begin
                        parse_state_next = vt100esc_pkg::ST_CSI2;
                    end else if (rx_byte == vt100esc_pkg::CH_QUEST) begin
                        parse_state_next = vt100esc_pkg::ST_QUEST;
                    end
                end
                vt100esc_pkg::ST_CSI2: begin
                    if (is_digit) begin
                        parse_state_next = vt100esc_pkg::ST_CSI2;
                    end
                end
                vt100esc_pkg::ST_QUEST: begin
                    if (is_digit || (rx_byte == vt100esc_pkg::CH_SEMI)) begin
                        parse_state_next = vt100esc_pkg::ST_QUEST;
                    end
                end
                default: begin
                    if (rx_byte == vt100esc_pkg::CH_ESC) begin
                        parse_state_next = vt100esc_pkg::ST_ESC;
                    end
                end
            endcase
        end
    end

    always_comb begin
        first_arg_next     = first_arg_reg;
        second_arg_next    = second_arg_reg;
        cursor_next        = cursor_reg;
        saved_next         = saved_reg;
        scroll_top_next    = scroll_top_reg;
        scroll_bottom_next = scroll_bottom_reg;
        attr_next          = attr_reg;
        cmd                = vt100esc_pkg::CMD_NONE;
        fill_start         = '0;
        fill_count         = '0;
        if (step_valid) begin
            unique case (parse_state_reg)
                vt100esc_pkg::ST_ESC: begin
                    unique case (rx_byte)
                        vt100esc_pkg::CH_LBRACKET: begin
                            first_arg_next  = '0;
                            second_arg_next = '0;
                        end
                        vt100esc_pkg::CH_UP_A: begin
                            if (cursor_reg >= vt100esc_pkg::CELL_W'(vt100esc_pkg::COLS)) begin
                                cursor_next = cursor_reg
                                            - vt100esc_pkg::CELL_W'(vt100esc_pkg::COLS);
                                cmd         = vt100esc_pkg::CMD_CURSOR;
                            end
                        end
                        vt100esc_pkg::CH_UP_C: begin
                            if (cursor_reg < vt100esc_pkg::CELL_W'(vt100esc_pkg::TOTAL - 1)) begin
                                cursor_next = cursor_reg + vt100esc_pkg::CELL_W'(1);
                                cmd         = vt100esc_pkg::CMD_CURSOR;
                            end
                        end
                        vt100esc_pkg::CH_UP_D: cmd = vt100esc_pkg::CMD_SCROLL_UP;
                        vt100esc_pkg::CH_UP_M: cmd = vt100esc_pkg::CMD_SCROLL_DOWN;
                        vt100esc_pkg::CH_SEVEN: saved_next = cursor_reg;
                        vt100esc_pkg::CH_EIGHT: begin
                            cursor_next = saved_reg;
                            cmd         = vt100esc_pkg::CMD_CURSOR;
                        end
                        default: ;
                    endcase
                end
                vt100esc_pkg::ST_CSI: begin
                    if (is_digit) begin
                        first_arg_next = vt100esc_pkg::add_digit(first_arg_reg, rx_byte[3:0]);
                    end else if ((rx_byte != vt100esc_pkg::CH_SEMI)
                                 && (rx_byte != vt100esc_pkg::CH_QUEST)) begin
                        unique case (rx_byte)
                            vt100esc_pkg::CH_UP_A: begin
                                cursor_next = (count_cols > pos_wide)
                                            ? vt100esc_pkg::CELL_W'(cur_col)
                                            : vt100esc_pkg::CELL_W'(pos_wide - count_cols);
                                cmd         = vt100esc_pkg::CMD_CURSOR;
                            end
                            vt100esc_pkg::CH_UP_B: begin
                                cursor_next = (down_sum >= vt100esc_pkg::MUL_W'(vt100esc_pkg::TOTAL))
                                            ? vt100esc_pkg::CELL_W'(vt100esc_pkg::LAST_ROW_BASE)
                                              + vt100esc_pkg::CELL_W'(cur_col)
                                            : down_sum[vt100esc_pkg::CELL_W-1:0];
                                cmd         = vt100esc_pkg::CMD_CURSOR;
                            end
                            vt100esc_pkg::CH_UP_C: begin
                                cursor_next = (right_sum >= vt100esc_pkg::MUL_W'(vt100esc_pkg::TOTAL))
                                            ? vt100esc_pkg::CELL_W'(vt100esc_pkg::TOTAL - 1)
                                            : right_sum[vt100esc_pkg::CELL_W-1:0];
                                cmd         = vt100esc_pkg::CMD_CURSOR;
                            end
                            vt100esc_pkg::CH_UP_D: begin
                                cursor_next = (vt100esc_pkg::ARG_W'(cursor_reg) >= count_arg)
                                            ? cursor_reg
                                              - count_arg[vt100esc_pkg::CELL_W-1:0]
                                            : '0;
                                cmd         = vt100esc_pkg::CMD_CURSOR;
                            end
                            vt100esc_pkg::CH_UP_H: begin
                                cursor_next = '0;
                                cmd         = vt100esc_pkg::CMD_CURSOR;
                            end
                            vt100esc_pkg::CH_UP_J: begin
                                if (first_arg_reg == vt100esc_pkg::ERASE_TO_END) begin
                                    fill_start = cursor_reg;
                                    fill_count = vt100esc_pkg::CELL_W'(vt100esc_pkg::TOTAL)
                                               - cursor_reg;
                                    cmd        = vt100esc_pkg::CMD_FILL;
                                end else if (first_arg_reg == vt100esc_pkg::ERASE_TO_START) begin
                                    fill_count = cursor_reg + vt100esc_pkg::CELL_W'(1);
                                    cmd        = vt100esc_pkg::CMD_FILL;
                                end else if (first_arg_reg == vt100esc_pkg::ERASE_ALL) begin
                                    fill_count = vt100esc_pkg::CELL_W'(vt100esc_pkg::TOTAL);
                                    cmd        = vt100esc_pkg::CMD_FILL;
                                end
                            end
                            vt100esc_pkg::CH_UP_K: begin
                                if (first_arg_reg == vt100esc_pkg::ERASE_TO_END) begin
                                    fill_start = cursor_reg;
                                    fill_count = vt100esc_pkg::CELL_W'(vt100esc_pkg::COLS)
                                               - vt100esc_pkg::CELL_W'(cur_col);
                                    cmd        = vt100esc_pkg::CMD_FILL;
                                end else if (first_arg_reg == vt100esc_pkg::ERASE_TO_START) begin
                                    fill_start = cursor_reg - vt100esc_pkg::CELL_W'(cur_col);
                                    fill_count = vt100esc_pkg::CELL_W'(cur_col)
                                               + vt100esc_pkg::CELL_W'(1);
                                    cmd        = vt100esc_pkg::CMD_FILL;
                                end else if (first_arg_reg == vt100esc_pkg::ERASE_ALL) begin
                                    fill_start = cursor_reg - vt100esc_pkg::CELL_W'(cur_col);
                                    fill_count = vt100esc_pkg::CELL_W'(vt100esc_pkg::COLS);
                                    cmd        = vt100esc_pkg::CMD_FILL;
                                end
                            end
                            vt100esc_pkg::CH_LOW_M: begin
                                if (first_arg_reg == vt100esc_pkg::SGR_RESET) begin
                                    attr_next = normal_attr;
                                end else if (first_arg_reg == vt100esc_pkg::SGR_BOLD) begin
                                    attr_next = attr_reg | vt100esc_pkg::ATTR_BOLD;
                                end else if (first_arg_reg == vt100esc_pkg::SGR_DIM) begin
                                    attr_next = attr_reg & ~vt100esc_pkg::ATTR_BOLD;
                                end else if (first_arg_reg == vt100esc_pkg::SGR_BLINK) begin
                                    attr_next = attr_reg | vt100esc_pkg::ATTR_BLINK;
                                end else if (first_arg_reg == vt100esc_pkg::SGR_REVERSE) begin
                                    attr_next = {rev_hb, 8'h00};
                                end else if ((first_arg_reg >= vt100esc_pkg::SGR_FG_FIRST)
                                             && (first_arg_reg <= vt100esc_pkg::SGR_FG_LAST)) begin
                                    attr_next = {attr_reg[15:11], fg_code[2:0], attr_reg[7:0]};
                                end else if (first_arg_reg == vt100esc_pkg::SGR_FG_DEFAULT) begin
                                    attr_next = {attr_reg[15:11], normal_attr[10:8], attr_reg[7:0]};
                                end else if ((first_arg_reg >= vt100esc_pkg::SGR_BG_FIRST)
                                             && (first_arg_reg <= vt100esc_pkg::SGR_BG_LAST)) begin
                                    attr_next = {attr_reg[15], bg_code[2:0], attr_reg[11:0]};
                                end else if (first_arg_reg == vt100esc_pkg::SGR_BG_DEFAULT) begin
                                    attr_next = {attr_reg[15], normal_attr[14:12], attr_reg[11:0]};
                                end
                            end
                            default: ;
                        endcase
                    end
                end
                vt100esc_pkg::ST_CSI2: begin
                    if (is_digit) begin
                        second_arg_next = vt100esc_pkg::add_digit(second_arg_reg, rx_byte[3:0]);
                    end else if (rx_byte == vt100esc_pkg::CH_UP_H) begin
                        cursor_next = vt100esc_pkg::CELL_W'(arg_row)
                                    * vt100esc_pkg::CELL_W'(vt100esc_pkg::COLS)
                                    + vt100esc_pkg::CELL_W'(arg_col);
                        cmd         = vt100esc_pkg::CMD_CURSOR;
                    end else if (rx_byte == vt100esc_pkg::CH_LOW_M) begin
                        if ((first_arg_reg == vt100esc_pkg::SGR_BOLD)
                            && (second_arg_reg == vt100esc_pkg::SGR_REVERSE)) begin
                            attr_next = attr_reg | vt100esc_pkg::ATTR_BOLD;
                        end
                    end else if (rx_byte == vt100esc_pkg::CH_LOW_R) begin
                        if (arg_row < arg_row2) begin
                            scroll_top_next    = arg_row;
                            scroll_bottom_next = arg_row2;
                        end
                    end
                end
                vt100esc_pkg::ST_QUEST: begin
                    if (is_digit) begin
                        second_arg_next = vt100esc_pkg::add_digit(second_arg_reg, rx_byte[3:0]);
                    end
                end
                default: ;
            endcase
        end
    end

    always_comb begin
        result.command       = cmd;
        result.cursor_pos    = cursor_next;
        result.fill_start    = fill_start;
        result.fill_count    = fill_count;
        result.region_top    = scroll_top_next;
        result.region_bottom = scroll_bottom_next;
        result.fill_word     = normal_attr | vt100esc_pkg::ATTR_W'(vt100esc_pkg::CH_SPACE);
        result.char_attr     = attr_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            parse_state_reg   <= vt100esc_pkg::ST_NORMAL;
            first_arg_reg     <= '0;
            second_arg_reg    <= '0;
            cursor_reg        <= '0;
            saved_reg         <= '0;
            scroll_top_reg    <= '0;
            scroll_bottom_reg <= vt100esc_pkg::ROW_W'(vt100esc_pkg::ROWS - 1);
            attr_reg          <= vt100esc_pkg::ATTR_DEFAULT;
            row_reg           <= '0;
        end else begin
            parse_state_reg   <= parse_state_next;
            first_arg_reg     <= first_arg_next;
            second_arg_reg    <= second_arg_next;
            cursor_reg        <= cursor_next;
            saved_reg         <= saved_next;
            scroll_top_reg    <= scroll_top_next;
            scroll_bottom_reg <= scroll_bottom_next;
            attr_reg          <= attr_next;
            row_reg           <= row_next;
        end
    end

    a_cursor_in_screen: assert property (@(posedge aclk) disable iff (!aresetn)
        cursor_reg < vt100esc_pkg::CELL_W'(vt100esc_pkg::TOTAL))
        else $error("cursor cell outside the screen");

    a_region_ordered: assert property (@(posedge aclk) disable iff (!aresetn)
        (scroll_top_reg < scroll_bottom_reg)
        && (scroll_bottom_reg < vt100esc_pkg::ROW_W'(vt100esc_pkg::ROWS)))
        else $error("scroll region out of order");

    a_row_current: assert property (@(posedge aclk) disable iff (!aresetn)
        (step_valid && (parse_state_reg == vt100esc_pkg::ST_CSI))
        |-> (col_full < vt100esc_pkg::CELL_W'(vt100esc_pkg::COLS)))
        else $error("registered cursor row is stale at a CSI byte");

    a_fill_span: assert property (@(posedge aclk) disable iff (!aresetn)
        (step_valid && (cmd == vt100esc_pkg::CMD_FILL))
        |-> ((fill_count != '0)
             && ((12'(fill_start) + 12'(fill_count)) <= 12'(vt100esc_pkg::TOTAL))))
        else $error("fill span leaves the screen");

    a_text_stays_normal: assert property (@(posedge aclk) disable iff (!aresetn)
        (step_valid && (parse_state_reg == vt100esc_pkg::ST_NORMAL)
         && (rx_byte != vt100esc_pkg::CH_ESC))
        |=> (parse_state_reg == vt100esc_pkg::ST_NORMAL))
        else $error("plain text left the normal state");

endmodule

`default_nettype wire

[rtl/vt100_escape_parser_top.sv]
// Top level of the terminal escape parser: stream ports, input and result registers.
`timescale 1ns / 1ps
`default_nettype none

// Channel   Direction  Width  Contents
// s_axis    in         8      rx_byte, one terminal byte per transaction
// m_axis    out        80     one result transaction per accepted byte
// cfg       in         16     normal_attr; the user must write it only while the parser is idle (not enforced)
//
// An accepted byte is held in the input register, then decoded into the result register that drives m_axis.
// A new byte can be accepted in every cycle while m_axis does not stall; the cursor update loop sets the rate.
// s_axis_tready falls only when the input and result registers are both full and
// m_axis_tready is low.
// Reset clears the parser to the normal state, cursor and saved cell to zero, the
// scroll region to the full screen and both attribute words to 0x0700.

module vt100_escape_parser_top (
    input  wire logic                                     aclk,
    input  wire logic                                     aresetn,
    input  wire logic                                     s_axis_tvalid,
    output logic                                          s_axis_tready,
    input  wire logic [7:0]                               s_axis_tdata,  // rx_byte
    output logic                                          m_axis_tvalid,
    input  wire logic                                     m_axis_tready,
    // command, cursor_pos, fill_start, fill_count, region_top, region_bottom,
    // fill_word, char_attr, zero padding
    output logic [vt100esc_pkg::OUT_TDATA_W-1:0]          m_axis_tdata,
    input  wire logic                                     cfg_we,
    input  wire logic [vt100esc_pkg::ATTR_W-1:0]          cfg_wdata
);

    logic                                 in_valid_reg, in_valid_next;
    logic [vt100esc_pkg::BYTE_W-1:0]      in_byte_reg;
    logic                                 out_valid_reg, out_valid_next;
    vt100esc_pkg::result_t                out_data_reg;
    logic [vt100esc_pkg::ATTR_W-1:0]      normal_attr_reg;
    logic                                 s_accept;
    logic                                 advance;
    vt100esc_pkg::result_t                step_result;

    assign advance       = in_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || advance;
    assign s_accept      = s_axis_tvalid && s_axis_tready;

    assign in_valid_next  = s_accept ? 1'b1 : (advance ? 1'b0 : in_valid_reg);
    assign out_valid_next = advance ? 1'b1 : (m_axis_tready ? 1'b0 : out_valid_reg);

    vt100esc_core u_core (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .step_valid  (advance),
        .rx_byte     (in_byte_reg),
        .normal_attr (normal_attr_reg),
        .result      (step_result)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg    <= 1'b0;
            out_valid_reg   <= 1'b0;
            normal_attr_reg <= vt100esc_pkg::ATTR_DEFAULT;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            if (cfg_we) begin
                normal_attr_reg <= cfg_wdata;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            in_byte_reg <= s_axis_tdata;
        end
        if (advance) begin
            out_data_reg <= step_result;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {{vt100esc_pkg::OUT_PAD_W{1'b0}}, out_data_reg};

    a_held_byte: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_valid_reg && !advance) |=> (in_valid_reg && $stable(in_byte_reg)))
        else $error("waiting input byte was lost or changed");

    a_stall_only_when_full: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_axis_tready |-> (in_valid_reg && out_valid_reg && !m_axis_tready))
        else $error("input stalled with room in the pipeline");

    a_command_code: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg |-> (out_data_reg.command <= vt100esc_pkg::CMD_SCROLL_DOWN))
        else $error("result carries an undefined command");

endmodule

`default_nettype wire
